// ----- rtl/sil_pkg.sv -----
// shared constants, codes and types for the sorted insertion list
package sil_pkg;

  // list capacity and derived widths
  localparam int DEPTH       = 32;
  localparam int VAL_W       = 32;
  localparam int KIND_W      = 2;
  localparam int ENT_W       = 6;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int OUT_TDATA_W = ((VAL_W + 1 + ENT_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - VAL_W - 1 - ENT_W;

  // item kinds carried on in_tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DRAIN  = 2'd2
  } kind_t;

  // one request to the entry store per cycle, with a write and a read
  typedef struct packed {
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/sorted_insertion_list.sv -----
// top level of the sorted insertion list
//
//   channel | direction | tdata                               | tuser  | tlast
//   in_     | slave     | new_value                           | kind   | -
//   out_    | master    | out_value, status, entries_now, pad | -      | last
//
// append: write at the tail, then the status beat; sorted insert: a scan of the stored
// entries first, one stored entry per cycle through the single read port of the store.
// drain: one entry beat per cycle after a registered read, while out_tready is high.
// a status beat may wait in the output register while the next item is taken.
// rst_n is synchronous and active low; it empties the list, the store is not cleared.
module sorted_insertion_list
  import sil_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic signed [VAL_W-1:0] in_tdata,        // [31:0] new_value
  input  logic [KIND_W-1:0]       in_tuser,        // [1:0] kind
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,       // [31:0] out_value, [32] status,
                                                   // [38:33] entries_now, [39] zero
  output logic                    out_tlast
);

  mem_req_t                mem_req;
  logic signed [VAL_W-1:0] rd_data;

  // sequencer with the shared compare step
  sil_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  // entry store
  sil_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/sil_store.sv -----
// entry store: one write port and one registered read port
module sil_store
  import sil_pkg::*;
(
  input  logic                    clk,
  input  mem_req_t                mem_req,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/sil_seq.sv -----
// sequencer: scans the store one entry a cycle through a shared compare and carry step
module sil_seq
  import sil_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic signed [VAL_W-1:0] in_tdata,
  input  logic [KIND_W-1:0]       in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tlast,
  output mem_req_t                mem_req,
  input  logic signed [VAL_W-1:0] rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_RESULT,
    S_DRAIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] hold_r, hold_nxt;
  logic                    found_r, found_nxt;
  logic                    full_r, full_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_status_r, out_status_nxt;
  logic [ENT_W-1:0]        out_ent_r, out_ent_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    out_free;
  logic [CNT_W-1:0]        idx_inc;
  logic                    take;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
  // shared compare: the new value goes before the first entry not below it
  assign take      = found_r || (val_r <= rd_data);

  // next-state and store access
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    hold_nxt       = hold_r;
    found_nxt      = found_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_last_nxt   = out_last_r;
    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(in_tuser))
            KIND_APPEND, KIND_INSERT: begin
              val_nxt   = in_tdata;
              hold_nxt  = in_tdata;
              found_nxt = 1'b0;
              idx_nxt   = '0;
              full_nxt  = (count_r == CNT_W'(DEPTH));
              if (count_r == CNT_W'(DEPTH)) begin
                state_nxt = S_RESULT;
              end else if (kind_t'(in_tuser) == KIND_INSERT && count_r != '0) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                state_nxt       = S_SCAN;
              end else begin
                state_nxt = S_TAIL;
              end
            end
            KIND_DRAIN: begin
              if (count_r != '0) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                idx_nxt         = '0;
                state_nxt       = S_DRAIN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // one entry a cycle: once the slot is found, each entry moves up by one
      S_SCAN: begin
        if (take) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = idx_r;
          mem_req.wr_data = hold_r;
          hold_nxt        = rd_data;
          found_nxt       = 1'b1;
        end
        if (idx_inc == count_r) begin
          state_nxt = S_TAIL;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_inc[IDX_W-1:0];
          idx_nxt         = idx_inc[IDX_W-1:0];
        end
      end

      // the held value lands at the tail
      S_TAIL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = count_r[IDX_W-1:0];
        mem_req.wr_data = hold_r;
        count_nxt       = count_r + CNT_W'(1);
        state_nxt       = S_RESULT;
      end

      // status beat
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = full_r;
          out_ent_nxt    = ENT_W'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // one entry beat per cycle while the output side keeps up
      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data;
          out_status_nxt = 1'b0;
          out_ent_nxt    = '0;
          out_last_nxt   = (idx_inc == count_r);
          if (idx_inc == count_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_inc[IDX_W-1:0];
            idx_nxt         = idx_inc[IDX_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    hold_r       <= hold_nxt;
    found_r      <= found_nxt;
    full_r       <= full_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_ent_r, out_status_r, out_value_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/sil_chk.sv -----
// port checker for the sorted insertion list and its bind
module sil_chk
  import sil_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [KIND_W-1:0]      in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // a failed append or insert is a single zero-valued last beat
  a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[VAL_W] |-> out_tdata[VAL_W-1:0] == '0 && out_tlast)
    else $error("full status beat malformed");

  // beats before the last one come only from a drain
  a_drain_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[VAL_W] && out_tdata[VAL_W+ENT_W:VAL_W+1] == '0)
    else $error("drain beat carries status or count");

  // an append or insert always keeps the sequencer busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_APPEND || in_tuser == KIND_INSERT)
      |=> !in_tready)
    else $error("input ready straight after an append or insert");

endmodule

bind sorted_insertion_list sil_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
